[design/lin_response_receiver_core_assert.svh]
// Assertion macros for the LIN response receiver.
// All of them sample on clk and stand down while rst_n is low.
`ifndef LIN_RESPONSE_RECEIVER_CORE_ASSERT_SVH
`define LIN_RESPONSE_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lrr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

    // Largest store the design supports (eight data bytes plus checksum).
    localparam int unsigned STORE_MAX = 9;
    localparam int unsigned LEN_W     = 4;

    // Diagnostic frame ids, always checked with the classic checksum.
    localparam logic [5:0] ID_DIAG_MASTER = 6'h3C;
    localparam logic [5:0] ID_DIAG_SLAVE  = 6'h3D;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    // One closed frame, as handed from front to back.
    typedef struct packed {
        logic [7:0]                 pid;
        logic [STORE_MAX-1:0][7:0]  bytes;
        logic [LEN_W-1:0]           len;   // zero means too few bytes
        logic                       ok;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

endpackage

`default_nettype wire

[design/lrr_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lrr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] frame_id;
    logic [7:0] rx_byte;

    modport source (output valid, operation, frame_id, rx_byte, input ready);
    modport sink   (input valid, operation, frame_id, rx_byte, output ready);
endinterface

interface lrr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] protected_id;
    logic [7:0] data_out;
    logic       byte_present;
    logic       frame_ok;
    logic [3:0] length;
    logic       last;

    modport source (output valid, protected_id, data_out, byte_present, frame_ok,
                    length, last, input ready);
    modport sink   (input valid, protected_id, data_out, byte_present, frame_ok,
                    length, last, output ready);
endinterface

interface lrr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[design/lrr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrr_queue
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  lrr_pkg::frame_rec_t    push_rec,
    input  wire                    pop,
    output lrr_pkg::frame_rec_t    pop_rec,
    output lrr_pkg::q_stat_t       stat
);

    lrr_pkg::frame_rec_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          fill_reg;
    logic [1:0]          fill_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (fill_reg == 2'd2);
    assign stat.empty = (fill_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_rec    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold entries until overwritten; no reset on payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

[design/lrr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrr_front
#(
    parameter int unsigned DEPTH = 9
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    lrr_cmd_if.sink                cmd,
    lrr_cfg_if.sink                cfg,
    input  lrr_pkg::q_stat_t       q_stat,
    output logic                   push,
    output lrr_pkg::frame_rec_t    push_rec
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                   enh_reg;
    logic                   open_reg;
    logic                   open_next;
    logic [7:0]             pid_reg;
    logic [7:0]             pid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [7:0]             sum_reg;
    logic [7:0]             sum_next;
    logic [DEPTH-1:0]       flags_reg;
    logic [DEPTH-1:0]       flags_next;
    logic [7:0]             store_reg  [DEPTH];
    logic [7:0]             store_next [DEPTH];

    logic                   accept;
    logic                   take_byte;
    logic                   closing;
    logic [8:0]             sum_wide;
    logic [7:0]             new_pid;
    logic [CNT_W-1:0]       match;
    lrr_pkg::op_t           op;

    assign cfg.ready = 1'b1;
    assign cmd.ready = !q_stat.full;
    assign accept    = cmd.valid && cmd.ready;
    assign op        = lrr_pkg::op_t'(cmd.operation);
    assign new_pid   = lrr_pkg::make_pid(cmd.frame_id);
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, cmd.rx_byte};

    always_comb
    begin
        open_next  = open_reg;
        pid_next   = pid_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        flags_next = flags_reg;
        take_byte  = 1'b0;
        closing    = 1'b0;
        if (accept)
        begin
            case (op)
                lrr_pkg::OP_START:
                begin
                    open_next  = 1'b1;
                    pid_next   = new_pid;
                    count_next = '0;
                    flags_next = '0;
                    if (enh_reg && cmd.frame_id != lrr_pkg::ID_DIAG_MASTER
                        && cmd.frame_id != lrr_pkg::ID_DIAG_SLAVE)
                        sum_next = new_pid;
                    else
                        sum_next = 8'd0;
                end
                lrr_pkg::OP_BYTE:
                begin
                    if (open_reg && count_reg < CNT_W'(DEPTH))
                    begin
                        take_byte  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        // Flag the byte if it closes the sum so far.
                        flags_next[count_reg] = (cmd.rx_byte == ~sum_reg);
                        // End-around carry: a carry out adds one back in.
                        sum_next   = sum_wide[8] ? sum_wide[7:0] + 8'd1 : sum_wide[7:0];
                        if (count_next == CNT_W'(DEPTH))
                        begin
                            closing   = 1'b1;
                            open_next = 1'b0;
                        end
                    end
                end
                lrr_pkg::OP_END:
                begin
                    if (open_reg)
                    begin
                        closing   = 1'b1;
                        open_next = 1'b0;
                    end
                end
                default:
                begin
                    open_next = open_reg;
                end
            endcase
        end
    end

    // Write the new byte into its slot.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            store_next[i] = store_reg[i];
            if (take_byte && count_reg == CNT_W'(i))
            begin
                store_next[i] = cmd.rx_byte;
            end
        end
    end

    // Largest length of at least one whose checksum matched.
    always_comb
    begin
        match = '0;
        for (int k = 1; k < DEPTH; k++)
        begin
            if (CNT_W'(k) < count_next && flags_next[k])
                match = CNT_W'(k);
        end
    end

    always_comb
    begin
        push_rec.pid   = pid_reg;
        push_rec.bytes = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            push_rec.bytes[i] = store_next[i];
        end
        if (count_next < CNT_W'(2))
        begin
            push_rec.len = '0;
            push_rec.ok  = 1'b0;
        end
        else if (match != '0)
        begin
            push_rec.len = lrr_pkg::LEN_W'(match);
            push_rec.ok  = 1'b1;
        end
        else
        begin
            push_rec.len = lrr_pkg::LEN_W'(count_next);
            push_rec.ok  = 1'b0;
        end
    end

    assign push = closing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enh_reg   <= 1'b1;
            open_reg  <= 1'b0;
            pid_reg   <= 8'd0;
            count_reg <= '0;
            sum_reg   <= 8'd0;
            flags_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                enh_reg <= cfg.data;
            open_reg  <= open_next;
            pid_reg   <= pid_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

endmodule

`default_nettype wire

[design/lrr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrr_back
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  lrr_pkg::q_stat_t       q_stat,
    input  lrr_pkg::frame_rec_t    pop_rec,
    output logic                   pop,
    lrr_result_if.source           result
);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t                     state_reg;
    lrr_pkg::frame_rec_t        cur_reg;
    logic [3:0]                 idx_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_pid_reg;
    logic [7:0]                 out_data_reg;
    logic                       out_present_reg;
    logic                       out_ok_reg;
    logic [lrr_pkg::LEN_W-1:0]  out_len_reg;
    logic                       out_last_reg;

    logic                       advance;
    logic                       is_last;
    logic                       empty_frame;

    assign advance     = !out_valid_reg || result.ready;
    assign pop         = (state_reg == ST_IDLE) && !q_stat.empty;
    assign empty_frame = (cur_reg.len == '0);
    assign is_last     = empty_frame || (idx_reg + 4'd1 == cur_reg.len);

    assign result.valid        = out_valid_reg;
    assign result.protected_id = out_pid_reg;
    assign result.data_out     = out_data_reg;
    assign result.byte_present = out_present_reg;
    assign result.frame_ok     = out_ok_reg;
    assign result.length       = out_len_reg;
    assign result.last         = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= 4'd0;
            out_valid_reg   <= 1'b0;
            out_pid_reg     <= 8'd0;
            out_data_reg    <= 8'd0;
            out_present_reg <= 1'b0;
            out_ok_reg      <= 1'b0;
            out_len_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (advance)
                        out_valid_reg <= 1'b0;
                    if (pop)
                    begin
                        state_reg <= ST_STREAM;
                        idx_reg   <= 4'd0;
                    end
                end
                ST_STREAM:
                begin
                    if (advance)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_pid_reg     <= cur_reg.pid;
                        out_data_reg    <= empty_frame ? 8'd0 : cur_reg.bytes[idx_reg];
                        out_present_reg <= !empty_frame;
                        out_ok_reg      <= cur_reg.ok;
                        out_len_reg     <= cur_reg.len;
                        out_last_reg    <= is_last;
                        if (is_last)
                            state_reg <= ST_IDLE;
                        else
                            idx_reg <= idx_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= pop_rec;
    end

endmodule

`default_nettype wire

[design/lin_response_receiver_core.sv]
// A closing item (end, or the byte that fills the store) gives its first result through the
// frame queue, the back end's record register (once it is idle) and the output register;
// the rest follow one a cycle while the sink takes them. Throughput: one item a cycle while
// the two-entry frame queue has room, and the queue sets how far the front runs on.
// Reset: frame closed, sum, count and flags cleared, enhanced checksum selected, queue and
// output empty; byte store contents undefined until written.
`timescale 1ns / 1ps
`default_nettype none

`include "lin_response_receiver_core_assert.svh"

module lin_response_receiver_core
#(
    parameter int unsigned MAX_DATA_BYTES = 8
)
(
    input  wire             clk,
    input  wire             rst_n,
    lrr_cmd_if.sink         cmd,
    lrr_cfg_if.sink         cfg,
    lrr_result_if.source    result
);

    // Data bytes plus the checksum byte.
    localparam int unsigned DEPTH = MAX_DATA_BYTES + 1;

    lrr_pkg::frame_rec_t    push_rec;
    lrr_pkg::frame_rec_t    pop_rec;
    lrr_pkg::q_stat_t       q_stat;
    logic                   push;
    logic                   pop;

    // Front: accept start, byte and end items, keep the running end-around-carry
    // sum and the per-byte checksum flags, and on close snapshot the frame,
    // its chosen length and its status into one queue record.
    lrr_front
    #(
        .DEPTH (DEPTH)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    // Queue: hold up to two closed frames so the front keeps taking items
    // while the back streams an earlier frame.
    lrr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .stat     (q_stat)
    );

    // Back: pop one record, stream its bytes through the output register,
    // one item a cycle while the sink takes them, or one empty failed item for a too-short frame.
    lrr_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .pop_rec (pop_rec),
        .pop     (pop),
        .result  (result)
    );

    // A full queue must stall the command side.
    `LRR_ASSERT_NOW(a_full_stalls, q_stat.full, !cmd.ready, "command accepted while queue full")
    // A record pushed into an empty queue is there on the next cycle.
    `LRR_ASSERT_NEXT(a_push_lands, push && q_stat.empty, !q_stat.empty, "pushed record lost")
    // An empty result closes its frame and reports nothing.
    `LRR_ASSERT_NOW(a_empty_result, result.valid && !result.byte_present,
        result.last && !result.frame_ok && result.length == 4'd0, "malformed empty result")
    // A passing frame always carries a byte and a non-zero length.
    `LRR_ASSERT_NOW(a_ok_has_data, result.valid && result.frame_ok,
        result.byte_present && result.length != 4'd0, "ok result without data")

endmodule

`default_nettype wire

[tb/lin_frame_checker.sv]
`timescale 1ns / 1ps

module lin_frame_checker
(
    input  wire         clk,
    input  wire         rst_n,
    lrr_cmd_if          cmd,
    lrr_cfg_if          cfg,
    lrr_result_if       result,
    output int unsigned errors,
    output int unsigned pending
);

    typedef struct packed {
        logic [7:0] pid;
        logic [7:0] data;
        logic       present;
        logic       ok;
        logic [3:0] len;
        logic       last;
    } byte_rec_t;

    byte_rec_t  expected_bytes[$];

    // Mirror of the receiver state
    logic       enhanced;
    logic       is_open;
    logic [7:0] frame_pid;
    logic [7:0] rx_store [0:lrr_pkg::STORE_MAX-1];
    int         rx_count;
    logic [7:0] rx_sum;
    logic [8:0] cks_hits;

    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = ^{id[4], id[2], id[1], id[0]};
        p1 = ~(^{id[5], id[4], id[3], id[1]});
        return {p1, p0, id};
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic present, input logic ok,
                              input logic [3:0] len, input logic last);
        byte_rec_t r;
        r.pid     = frame_pid;
        r.data    = data;
        r.present = present;
        r.ok      = ok;
        r.len     = len;
        r.last    = last;
        expected_bytes.push_back(r);
    endtask

    // Pick the longest length whose checksum matched, else return the raw bytes; under two bytes give one empty item
    task automatic close_frame;
        int best;
        best = 0;
        is_open = 1'b0;
        if (rx_count < 2)
        begin
            queue_byte(8'h00, 1'b0, 1'b0, 4'd0, 1'b1);
        end
        else
        begin
            for (int k = rx_count - 1; k >= 1; k--)
                if (cks_hits[k] && best == 0)
                    best = k;
            if (best > 0)
            begin
                for (int k = 0; k < best; k++)
                    queue_byte(rx_store[k], 1'b1, 1'b1, 4'(best), k == best - 1);
            end
            else
            begin
                for (int k = 0; k < rx_count; k++)
                    queue_byte(rx_store[k], 1'b1, 1'b0, 4'(rx_count), k == rx_count - 1);
            end
        end
    endtask

    task automatic take_item(input logic [1:0] op, input logic [5:0] id, input logic [7:0] b);
        logic [8:0] s;
        case (op)
            lrr_pkg::OP_START:
            begin
                frame_pid = protect_id(id);
                is_open   = 1'b1;
                rx_count  = 0;
                cks_hits  = '0;
                if (enhanced && id != lrr_pkg::ID_DIAG_MASTER && id != lrr_pkg::ID_DIAG_SLAVE)
                    rx_sum = frame_pid;
                else
                    rx_sum = 8'h00;
            end
            lrr_pkg::OP_BYTE:
            begin
                if (is_open && rx_count < lrr_pkg::STORE_MAX)
                begin
                    rx_store[rx_count] = b;
                    if (b == ~rx_sum)
                        cks_hits[rx_count] = 1'b1;
                    s = {1'b0, rx_sum} + {1'b0, b};
                    if (s > 9'd255)
                        s = s - 9'd255;
                    rx_sum   = s[7:0];
                    rx_count = rx_count + 1;
                    if (rx_count >= lrr_pkg::STORE_MAX)
                        close_frame();
                end
            end
            lrr_pkg::OP_END:
            begin
                if (is_open)
                    close_frame();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_result;
        byte_rec_t e;
        if (expected_bytes.size() == 0)
        begin
            errors = errors + 1;
            $display("%0t: unexpected result, expected none, got pid %h data %h last %b",
                     $time, result.protected_id, result.data_out, result.last);
        end
        else
        begin
            e = expected_bytes.pop_front();
            check_field("protected_id", e.pid, result.protected_id);
            check_field("data_out", e.data, result.data_out);
            check_field("byte_present", {7'd0, e.present}, {7'd0, result.byte_present});
            check_field("frame_ok", {7'd0, e.ok}, {7'd0, result.frame_ok});
            check_field("length", {4'd0, e.len}, {4'd0, result.length});
            check_field("last", {7'd0, e.last}, {7'd0, result.last});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enhanced  = 1'b1;
            is_open   = 1'b0;
            frame_pid = 8'h00;
            rx_count  = 0;
            rx_sum    = 8'h00;
            cks_hits  = '0;
            expected_bytes.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                enhanced = cfg.data;
            if (cmd.valid && cmd.ready)
                take_item(cmd.operation, cmd.frame_id, cmd.rx_byte);
            if (result.valid && result.ready)
                check_result();
            pending = expected_bytes.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Operation code the block must ignore
    localparam logic [1:0] OP_RSVD = 2'd3;

    // Cycles without any handshake before the run is declared hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Quiet time before a mode write and after the last result
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned DRAIN_CYCLES   = 30;
    localparam int unsigned PHASE_ITEMS    = 167;

    typedef enum int {
        FR_GOOD,    // data followed by its checksum
        FR_TAIL,    // checksum, then junk bytes after it
        FR_BAD,     // corrupted checksum
        FR_RAW,     // data only, no checksum
        FR_DROP     // never closed, dropped by the next start
    } frame_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned items_sent;
    int unsigned idle_cycles;
    int unsigned check_errors;
    int unsigned check_pending;
    logic        cur_enh;

    lrr_cmd_if    cmd_ch ();
    lrr_cfg_if    cfg_ch ();
    lrr_result_if res_ch ();

    always #4 clk = ~clk;

    lin_response_receiver_core #(
        .MAX_DATA_BYTES (8)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    lin_frame_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .cfg     (cfg_ch),
        .result  (res_ch),
        .errors  (check_errors),
        .pending (check_pending)
    );

    // Stall the result side at random; held low through reset
    always @(negedge clk)
    begin
        res_ch.ready = rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Offer one item, idling first at random, and return at the falling edge after
    // it has been taken. Valid stays high so back-to-back items need no gap.
    task automatic push_item(input logic [1:0] op, input logic [5:0] id, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.operation = op;
        cmd_ch.frame_id  = id;
        cmd_ch.rx_byte   = data;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted result has arrived
    task automatic hold_for_results;
        cmd_ch.valid = 1'b0;
        while (check_pending != 0)
            @(negedge clk);
    endtask

    // Write the checksum mode only once the block has drained
    task automatic write_mode(input logic enh);
        hold_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = enh;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cur_enh = enh;
    endtask

    // Bias data towards the extremes now and then
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Build a frame: start, data, checksum per kind, then an end unless the store filled or the kind is a drop
    task automatic send_frame(input logic [5:0] id, input int n_data, input frame_kind_t kind);
        logic [7:0] body [0:11];
        logic [7:0] sum_v;
        logic [8:0] s;
        int         nb;
        int         n_tail;
        nb = 0;
        if (cur_enh && id != lrr_pkg::ID_DIAG_MASTER && id != lrr_pkg::ID_DIAG_SLAVE)
            sum_v = lrr_pkg::make_pid(id);
        else
            sum_v = 8'h00;
        for (int k = 0; k < n_data; k++)
        begin
            body[nb] = pick_byte();
            s = {1'b0, sum_v} + {1'b0, body[nb]};
            if (s > 9'd255)
                s = s - 9'd255;
            sum_v = s[7:0];
            nb = nb + 1;
        end
        case (kind)
            FR_GOOD, FR_TAIL:
            begin
                body[nb] = ~sum_v;
                nb = nb + 1;
                if (kind == FR_TAIL)
                begin
                    n_tail = $urandom_range(1, 2);
                    for (int k = 0; k < n_tail; k++)
                    begin
                        body[nb] = pick_byte();
                        nb = nb + 1;
                    end
                end
            end
            FR_BAD:
            begin
                body[nb] = ~sum_v ^ 8'($urandom_range(1, 255));
                nb = nb + 1;
            end
            default:
            begin
            end
        endcase
        // Drop anything the full store would ignore
        if (nb > int'(lrr_pkg::STORE_MAX))
            nb = lrr_pkg::STORE_MAX;
        push_item(lrr_pkg::OP_START, id, pick_byte());
        for (int k = 0; k < nb; k++)
            push_item(lrr_pkg::OP_BYTE, 6'($urandom_range(63)), body[k]);
        if (nb < int'(lrr_pkg::STORE_MAX) && kind != FR_DROP)
            push_item(lrr_pkg::OP_END, 6'($urandom_range(63)), pick_byte());
    endtask

    // Mostly well-formed frames with random content, a share of broken ones and noise
    task automatic random_frame;
        logic [5:0]  id;
        int unsigned r;
        id = 6'($urandom_range(63));
        if ($urandom_range(7) == 0)
            id = $urandom_range(1) ? lrr_pkg::ID_DIAG_MASTER : lrr_pkg::ID_DIAG_SLAVE;
        r = $urandom_range(19);
        if (r < 12)
            send_frame(id, $urandom_range(8), FR_GOOD);
        else if (r < 15)
            send_frame(id, $urandom_range(7), FR_TAIL);
        else if (r < 17)
            send_frame(id, $urandom_range(8), FR_BAD);
        else if (r == 17)
            send_frame(id, $urandom_range(9), FR_RAW);
        else if (r == 18)
            send_frame(id, $urandom_range(5), FR_DROP);
        else
        begin
            case ($urandom_range(2))
                0: push_item(OP_RSVD, id, pick_byte());
                1: push_item(lrr_pkg::OP_BYTE, id, pick_byte());
                default: push_item(lrr_pkg::OP_END, id, pick_byte());
            endcase
        end
    endtask

    initial
    begin
        int unsigned phase_end;
        logic        flipped;

        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = lrr_pkg::OP_START;
        cmd_ch.frame_id  = 6'h00;
        cmd_ch.rx_byte   = 8'h00;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = 1'b0;
        tx_idle_pct      = 25;
        rx_idle_pct      = 55;
        items_sent       = 0;
        idle_cycles      = 0;
        cur_enh          = 1'b1;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: items with nothing open, and the reserved operation
        push_item(lrr_pkg::OP_END, 6'h2B, 8'hA5);
        push_item(lrr_pkg::OP_BYTE, 6'h14, 8'h5A);
        push_item(OP_RSVD, 6'h3F, 8'hFF);
        // Too few bytes: none, then one
        send_frame(6'h3F, 0, FR_RAW);
        send_frame(6'h00, 1, FR_RAW);
        // Diagnostic id, classic sum; the sum reaches 255 and must stay there
        push_item(lrr_pkg::OP_START, lrr_pkg::ID_DIAG_MASTER, 8'h00);
        push_item(lrr_pkg::OP_BYTE, 6'h00, 8'h00);
        push_item(lrr_pkg::OP_BYTE, 6'h3F, 8'hFF);
        push_item(lrr_pkg::OP_BYTE, 6'h00, 8'h00);
        push_item(lrr_pkg::OP_END, 6'h3F, 8'hFF);
        // Full store closes the frame without an end item
        send_frame(6'h15, 8, FR_GOOD);
        // Start while open drops the first frame
        send_frame(lrr_pkg::ID_DIAG_SLAVE, 2, FR_DROP);
        send_frame(6'h2A, 1, FR_GOOD);

        // Three phases of random frames; the mode flips halfway through each
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 55;
            end
            else if (phase == 1)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 25;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_mode(phase == 1);
            phase_end = items_sent + PHASE_ITEMS;
            flipped = 1'b0;
            while (items_sent < phase_end)
            begin
                random_frame();
                if (!flipped && items_sent + PHASE_ITEMS / 2 >= phase_end)
                begin
                    write_mode(~cur_enh);
                    flipped = 1'b1;
                end
            end
        end

        // Drain, then leave room for anything stray to show up
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_errors == 0 && check_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
